// File: hdl/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types and constants of the duplicate packet filter.
// ----------------------------------------------------------------------------
package dpf_pkg;

  localparam int unsigned NUM_W        = 32;
  localparam int unsigned WIN_W        = 11;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned PADDR_W      = 2;
  localparam int unsigned PDATA_W      = 32;

  localparam logic [WIN_W-1:0]   WIN_RESET       = 11'd1000;
  localparam logic [PADDR_W-1:0] REG_WINDOW_ADDR = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } dpf_state_e;

  typedef struct packed {
    logic clear;
    logic en;
  } dpf_cmp_ctl_t;

  typedef struct packed {
    logic match;
    logic have_min;
    logic min_below_num;
  } dpf_cmp_stat_t;

endpackage

// File: hdl/dpf_ram.sv
// ----------------------------------------------------------------------------
// dpf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dpf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/dpf_cmp_unit.sv
// ----------------------------------------------------------------------------
// dpf_cmp_unit
// Shared compare unit: match detection and running minimum over the scan.
// ----------------------------------------------------------------------------
module dpf_cmp_unit import dpf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpf_cmp_ctl_t                ctl_i,
  input  logic [NUM_W-1:0]            num_i,
  input  logic [NUM_W-1:0]            data_i,
  input  logic [$clog2(CAPACITY)-1:0] idx_i,
  output dpf_cmp_stat_t               stat_o,
  output logic [$clog2(CAPACITY)-1:0] min_idx_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic             have_min_q, have_min_d;
  logic [NUM_W-1:0] min_val_q, min_val_d;
  logic [AW-1:0]    min_idx_q, min_idx_d;
  logic             eq;
  logic             lt_min;

  assign eq     = (data_i == num_i);
  assign lt_min = (data_i < min_val_q);

  always_comb begin
    have_min_d = have_min_q;
    min_val_d  = min_val_q;
    min_idx_d  = min_idx_q;
    if (ctl_i.clear) begin
      have_min_d = 1'b0;
    end else if (ctl_i.en && !eq && (!have_min_q || lt_min)) begin
      have_min_d = 1'b1;
      min_val_d  = data_i;
      min_idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_min_q <= 1'b0;
    end else begin
      have_min_q <= have_min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_val_q <= min_val_d;
    min_idx_q <= min_idx_d;
  end

  assign stat_o.match         = ctl_i.en && eq;
  assign stat_o.have_min      = have_min_q;
  assign stat_o.min_below_num = have_min_q && (min_val_q < num_i);
  assign min_idx_o            = min_idx_q;

endmodule

// File: hdl/dpf_ctrl.sv
// ----------------------------------------------------------------------------
// dpf_ctrl
// Sequencer: scans stored entries, decides insert, evict or neither, holds result.
// ----------------------------------------------------------------------------
module dpf_ctrl import dpf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [NUM_W-1:0]            packet_number_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        is_new_o,
  input  logic [WIN_W-1:0]            window_i,
  output logic                        ram_we_o,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr_o,
  output logic [NUM_W-1:0]            ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr_o,
  output dpf_cmp_ctl_t                cmp_ctl_o,
  output logic [NUM_W-1:0]            cmp_num_o,
  output logic [$clog2(CAPACITY)-1:0] cmp_idx_o,
  input  dpf_cmp_stat_t               cmp_stat_i,
  input  logic [$clog2(CAPACITY)-1:0] cmp_min_idx_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = ((CW > WIN_W) ? CW : WIN_W) + 1;

  dpf_state_e       state_q, state_d;
  logic [NUM_W-1:0] num_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    issue_q, issue_d;
  logic             cvld_q;
  logic [AW-1:0]    cidx_q;
  logic             res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             is_new_q;

  logic             accept;
  logic             cmp_last;
  logic [LW-1:0]    limit;
  logic             full;
  logic             out_free;
  logic             out_load;

  assign accept   = in_valid_i && !in_stall_o;
  assign cmp_last = ((CW'(cidx_q) + CW'(1)) == count_q);
  assign limit    = (LW'(window_i) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(window_i);
  assign full     = ((LW'(count_q) + LW'(1)) > limit);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (count_q == '0) ? ST_DECIDE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cvld_q && cmp_stat_i.match) begin
          state_d = ST_EMIT;
        end else if (cvld_q && cmp_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    ram_re_o      = (state_q == ST_SCAN) && (issue_q < count_q);
    ram_raddr_o   = issue_q[AW-1:0];
    ram_we_o      = 1'b0;
    ram_waddr_o   = count_q[AW-1:0];
    ram_wdata_o   = num_q;
    cmp_ctl_o     = '{clear: (state_q == ST_IDLE), en: (state_q == ST_SCAN) && cvld_q};
    count_d       = count_q;
    res_d         = res_q;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        res_d = 1'b1;
      end
      ST_SCAN: begin
        if (cvld_q && cmp_stat_i.match) begin
          res_d = 1'b0;
        end
      end
      ST_DECIDE: begin
        res_d = 1'b1;
        if (full) begin
          ram_we_o    = cmp_stat_i.have_min && cmp_stat_i.min_below_num;
          ram_waddr_o = cmp_min_idx_i;
        end else begin
          ram_we_o = 1'b1;
          count_d  = count_q + CW'(1);
        end
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    issue_d = issue_q;
    if (state_q == ST_IDLE) begin
      issue_d = '0;
    end else if (ram_re_o) begin
      issue_d = issue_q + CW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      cvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      cvld_q      <= ram_re_o;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      num_q <= packet_number_in_i;
    end
    cidx_q <= issue_q[AW-1:0];
    res_q  <= res_d;
    if (out_load) begin
      is_new_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_new_o    = is_new_q;
  assign cmp_num_o   = num_q;
  assign cmp_idx_o   = cidx_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("entry count moved by more than one");

  a_write_in_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == ST_DECIDE))
    else $error("memory write outside decide step");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |-> (issue_q < count_q))
    else $error("read beyond filled entries");

endmodule

// File: hdl/duplicate_packet_filter_top.sv
// Each request scans the stored entries, then decides and emits its result;
// an empty set skips the scan, and a duplicate ends the scan early.
// The memory read port scans one stored entry per cycle. No new request is
// taken until the previous result is loaded into the output register, but one
// is taken while that result still waits in the output register.
// Reset clears fill count, sequencer and output valid, not the number memory.
// ----------------------------------------------------------------------------
// duplicate_packet_filter_top
// Duplicate packet suppression window with APB window-size register.
// ----------------------------------------------------------------------------
module duplicate_packet_filter_top import dpf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [NUM_W-1:0]   packet_number_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               is_new_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(CAPACITY);

  logic [WIN_W-1:0] window_q;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [NUM_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [NUM_W-1:0] ram_rdata;
  dpf_cmp_ctl_t     cmp_ctl;
  dpf_cmp_stat_t    cmp_stat;
  logic [NUM_W-1:0] cmp_num;
  logic [AW-1:0]    cmp_idx;
  logic [AW-1:0]    cmp_min_idx;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == REG_WINDOW_ADDR)) begin
      window_q <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr)
      REG_WINDOW_ADDR: prdata = PDATA_W'(window_q);
      default:         prdata = '0;
    endcase
  end

  dpf_ram #(
    .WIDTH (NUM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dpf_cmp_unit #(
    .CAPACITY (CAPACITY)
  ) u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (cmp_ctl),
    .num_i     (cmp_num),
    .data_i    (ram_rdata),
    .idx_i     (cmp_idx),
    .stat_o    (cmp_stat),
    .min_idx_o (cmp_min_idx)
  );

  dpf_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .packet_number_in_i (packet_number_in_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .is_new_o           (is_new_o),
    .window_i           (window_q),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .ram_re_o           (ram_re),
    .ram_raddr_o        (ram_raddr),
    .cmp_ctl_o          (cmp_ctl),
    .cmp_num_o          (cmp_num),
    .cmp_idx_o          (cmp_idx),
    .cmp_stat_i         (cmp_stat),
    .cmp_min_idx_i      (cmp_min_idx)
  );

endmodule

// File: sim/duplicate_packet_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_packet_filter_checker
// Watches the request, result and register channels of the duplicate packet
// filter. Keeps its own copy of the seen-number set and the window size,
// judges every accepted request in order and compares each accepted result
// with the oldest judgement. Window reads are checked against the last write.
// ----------------------------------------------------------------------------
module duplicate_packet_filter_checker import dpf_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [NUM_W-1:0]   pkt_num_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               is_new_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  input  logic [PDATA_W-1:0] prdata_i,
  input  logic               pready_i,
  output int                 mismatches_o,
  output int                 pending_o,
  output int                 fill_level_o
);

  logic [NUM_W-1:0] seen_num [CAPACITY];
  logic             seen_valid [CAPACITY];
  int unsigned      stored;
  logic [WIN_W-1:0] window;
  bit               novelty_q [$];
  int               mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic bit admit_packet(input logic [NUM_W-1:0] num);
    int unsigned      limit;
    bit               have_min;
    bit               have_free;
    logic [NUM_W-1:0] min_val;
    int unsigned      min_idx;
    int unsigned      free_idx;
    limit     = (window > CAPACITY) ? CAPACITY : window;
    have_min  = 1'b0;
    have_free = 1'b0;
    min_val   = '0;
    min_idx   = 0;
    free_idx  = 0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (seen_valid[i]) begin
        if (seen_num[i] == num) return 1'b0;
        if (!have_min || seen_num[i] < min_val) begin
          have_min = 1'b1;
          min_val  = seen_num[i];
          min_idx  = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = i;
      end
    end
    // evict the smallest of the set and the new number
    if (stored + 1 > limit) begin
      if (have_min && min_val < num) seen_num[min_idx] = num;
    end else if (have_free) begin
      seen_num[free_idx]   = num;
      seen_valid[free_idx] = 1'b1;
      stored++;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < CAPACITY; i++) seen_valid[i] = 1'b0;
      stored     = 0;
      window     = WIN_RESET;
      mismatches = 0;
      novelty_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == REG_WINDOW_ADDR) begin
        if (pwrite_i) begin
          window = pwdata_i[WIN_W-1:0];
        end else if (prdata_i !== PDATA_W'(window)) begin
          report_mismatch($sformatf("window reads %0h, expected %0h", prdata_i, window));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (novelty_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = novelty_q.pop_front();
          if (is_new_i !== want)
            report_mismatch($sformatf("is_new %b, expected %b", is_new_i, want));
        end
      end
      if (in_valid_i && !in_stall_i)
        novelty_q.insert(novelty_q.size(), admit_packet(pkt_num_i));
    end
    mismatches_o <= mismatches;
    pending_o    <= novelty_q.size();
    fill_level_o <= stored;
  end

endmodule

// File: sim/duplicate_packet_filter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duplicate_packet_filter_top_test
// Drives packet numbers through the duplicate packet filter under a range of
// window sizes: empty and tiny windows, windows lowered below the fill level,
// packet flows with duplicates and reordering, and a run of fresh numbers
// under a full-size window followed by an oversized window. Both channels
// idle at random; the checker beside the block predicts and compares every
// result.
// ----------------------------------------------------------------------------
module duplicate_packet_filter_top_test;
  import dpf_pkg::*;

  localparam int unsigned CAPACITY      = CAPACITY_DEF;
  localparam int          LIMIT_CYCLES  = 6_000_000;
  localparam int          DIRECTED_LEN  = 25;
  localparam int          RANDOM_PHASES = 7;
  localparam int          FILL_ITEMS    = 16;

  localparam logic [NUM_W-1:0] DIRECTED_NUMS [DIRECTED_LEN] = '{
    32'h0000_0005, 32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'h0000_0001,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
    32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE, 32'hAAAA_AAAA,
    32'h9000_0000, 32'h0000_0000, 32'h9000_0000, 32'hC000_0000, 32'hFFFF_FFFF
  };
  localparam int               DIRECTED_START [5] = '{0, 5, 11, 20, 25};
  localparam logic [WIN_W-1:0] DIRECTED_WIN [4]   = '{11'd0, 11'd1, 11'd4, 11'd2};

  localparam logic [WIN_W-1:0] RANDOM_WIN [RANDOM_PHASES] = '{
    11'd3, 11'd8, 11'd33, 11'd128, 11'd300, 11'd16, 11'd1000
  };
  localparam int RANDOM_ITEMS [RANDOM_PHASES] = '{80, 80, 80, 80, 80, 70, 50};

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [NUM_W-1:0]   pkt_num       = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               is_new;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [PDATA_W-1:0] pwdata        = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int pending;
  int fill_level;
  int cycle_count = 0;
  bit calm        = 1'b0;

  logic [NUM_W-1:0] recent [64];
  int               recent_n  = 0;
  int               recent_wr = 0;
  logic [NUM_W-1:0] flow      = '0;

  duplicate_packet_filter_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .packet_number_in_i(pkt_num),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .is_new_o          (is_new),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  duplicate_packet_filter_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .pkt_num_i      (pkt_num),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .is_new_i       (is_new),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_i       (prdata),
    .pready_i       (pready),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .fill_level_o   (fill_level)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** duplicate_packet_filter_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 12);
  end

  task automatic apb_access(input bit write, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= REG_WINDOW_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [PDATA_W-1:0] value);
    apb_access(1'b1, value);
    apb_access(1'b0, '0);
  endtask

  task automatic send_request(input logic [NUM_W-1:0] num);
    int gap;
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pkt_num  <= num;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every result is back
  task automatic finish_phase();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [NUM_W-1:0] pick_packet();
    int               roll;
    logic [NUM_W-1:0] num;
    roll = $urandom_range(99);
    if (roll < 35 && recent_n > 0) begin
      num = recent[$urandom_range(recent_n - 1)];
    end else if (roll < 75) begin
      if ($urandom_range(9) == 0) begin
        num = flow - NUM_W'($urandom_range(1, 8));
      end else begin
        flow = flow + NUM_W'($urandom_range(1, 4));
        num  = flow;
      end
    end else if (roll < 90) begin
      num = $urandom;
    end else begin
      case ($urandom_range(5))
        0:       num = 32'h0000_0000;
        1:       num = 32'h0000_0001;
        2:       num = 32'hFFFF_FFFF;
        3:       num = 32'hFFFF_FFFE;
        4:       num = 32'h8000_0000;
        default: num = 32'h7FFF_FFFF;
      endcase
    end
    recent[recent_wr] = num;
    recent_wr         = (recent_wr + 1) % 64;
    if (recent_n < 64) recent_n++;
    return num;
  endfunction

  initial begin
    logic [NUM_W-1:0] fill_tag;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    apb_access(1'b0, '0);

    for (int p = 0; p < 4; p++) begin
      set_window(PDATA_W'(DIRECTED_WIN[p]));
      for (int k = DIRECTED_START[p]; k < DIRECTED_START[p+1]; k++)
        send_request(DIRECTED_NUMS[k]);
      finish_phase();
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm <= (p == 2);
      flow  = (p == 4) ? 32'hFFFF_FFC0 : NUM_W'($urandom);
      set_window(PDATA_W'(RANDOM_WIN[p]));
      for (int k = 0; k < RANDOM_ITEMS[p]; k++) send_request(pick_packet());
      finish_phase();
    end
    calm <= 1'b0;

    set_window(PDATA_W'(CAPACITY));
    fill_tag = 32'h4000_0000;
    for (int k = 0; k < FILL_ITEMS && fill_level < CAPACITY; k++) begin
      send_request(fill_tag);
      fill_tag += 32'd7;
    end
    finish_phase();

    set_window(32'hFFFF_FFFF);
    for (int k = 0; k < 24; k++) send_request(pick_packet());
    finish_phase();

    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("** duplicate_packet_filter_top: PASSED **");
    end else begin
      $display("** duplicate_packet_filter_top: FAILED **");
    end
    $finish;
  end

endmodule
